### src/mstk_pkg.sv
// ----------------------------------------------------------------------------
// mstk_pkg: shared constants
// field widths and default sizes for the kruskal spanning tree core
// ----------------------------------------------------------------------------
`default_nettype none

package mstk_pkg;

  localparam int VERTEX_W   = 8;
  localparam int WEIGHT_W   = 16;
  localparam int COST_W     = 24;
  localparam int NVERT_W    = 9;
  localparam int EDGE_W     = 2 * VERTEX_W + WEIGHT_W;

  localparam int DEF_MAX_VERTICES = 256;
  localparam int DEF_MAX_EDGES    = 1024;

endpackage

`default_nettype wire

### src/mstk_if.sv
// ----------------------------------------------------------------------------
// mstk_in_if / mstk_out_if: edge and result channels
// valid/ready channels carrying one edge or one result per transaction
// ----------------------------------------------------------------------------
`default_nettype none

interface mstk_in_if import mstk_pkg::*; ();
  logic                valid;
  logic                ready;
  logic [VERTEX_W-1:0] first_vertex;
  logic [VERTEX_W-1:0] second_vertex;
  logic [WEIGHT_W-1:0] edge_weight;
  logic                edge_present;
  logic                last_edge;

  modport source (output valid, first_vertex, second_vertex, edge_weight,
                  edge_present, last_edge, input ready);
  modport sink   (input valid, first_vertex, second_vertex, edge_weight,
                  edge_present, last_edge, output ready);
endinterface

interface mstk_out_if import mstk_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              connected;
  logic [COST_W-1:0] total_cost;
  logic              input_error;

  modport source (output valid, connected, total_cost, input_error, input ready);
  modport sink   (input valid, connected, total_cost, input_error, output ready);
endinterface

`default_nettype wire

### src/minimum_spanning_tree_kruskal_core.sv
// ----------------------------------------------------------------------------
// minimum_spanning_tree_kruskal_core: kruskal spanning tree engine
// stores edges, then walks them in ascending weight through a union-find
// ----------------------------------------------------------------------------
// channel   | dir | contents
// in_edge   | in  | first_vertex, second_vertex, edge_weight, edge_present,
//           |     | last_edge
// out_res   | out | connected, total_cost, input_error
// cfg       | in  | cfg_we / cfg_wdata write num_vertices
//
// loading takes one edge transaction per cycle into the edge memory
// after the last edge: a clearing pass over the parent memory, then per
// distinct weight one min-search sweep and one processing sweep (with find
// steps and a union for each in-range edge of that weight), and, unless the
// tree completes early, a closing min-search sweep that finds nothing
// the shared edge memory read port and parent memory read port set the pace
// in_edge.ready is low from the last edge until the result is registered
// reset is synchronous; the result register frees as soon as out_res takes it
// ----------------------------------------------------------------------------
`default_nettype none

module minimum_spanning_tree_kruskal_core import mstk_pkg::*; #(
  parameter int MAX_EDGES    = DEF_MAX_EDGES
) (
  input  wire                clk,
  input  wire                rst,
  input  wire                cfg_we,
  input  wire [NVERT_W-1:0]  cfg_wdata,
  mstk_in_if.sink            in_edge,
  mstk_out_if.source         out_res
);

  // vertex count is tied to the field widths of the package
  localparam int MAX_VERTICES = DEF_MAX_VERTICES;

  localparam int VW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
  localparam int NW = $clog2(MAX_VERTICES + 1);
  localparam int AW = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
  localparam int EW = $clog2(MAX_EDGES + 1);

  localparam logic [3:0] S_LOAD    = 4'd0;
  localparam logic [3:0] S_CLR     = 4'd1;
  localparam logic [3:0] S_MIN_RD  = 4'd2;
  localparam logic [3:0] S_MIN_CHK = 4'd3;
  localparam logic [3:0] S_PR_RD   = 4'd4;
  localparam logic [3:0] S_PR_CHK  = 4'd5;
  localparam logic [3:0] S_FA_RD   = 4'd6;
  localparam logic [3:0] S_FA_CHK  = 4'd7;
  localparam logic [3:0] S_FB_RD   = 4'd8;
  localparam logic [3:0] S_FB_CHK  = 4'd9;
  localparam logic [3:0] S_UNION   = 4'd10;
  localparam logic [3:0] S_DONE    = 4'd11;

  // configuration and its clamped value
  logic [NVERT_W-1:0] num_vertices;
  logic [NW-1:0]      n_act;

  always_comb begin
    if (num_vertices == '0) begin
      n_act = NW'(1);
    end else if (32'(num_vertices) > MAX_VERTICES) begin
      n_act = NW'(MAX_VERTICES);
    end else begin
      n_act = NW'(num_vertices);
    end
  end

  // control registers
  logic [3:0]          state;
  logic [EW-1:0]       edge_count;
  logic                error_flag;
  logic [NW-1:0]       n_run;
  logic [EW-1:0]       idx;
  logic [VW-1:0]       clr;
  logic                have_prev;
  logic                found;
  logic [WEIGHT_W-1:0] prev_w;
  logic [WEIGHT_W-1:0] min_w;
  logic [WEIGHT_W-1:0] cur_w;
  logic [VW-1:0]       ra;
  logic [VW-1:0]       rb;
  logic [NW-1:0]       comp_count;
  logic [NW-1:0]       acc_count;
  logic [COST_W-1:0]   cost_sum;
  logic                out_valid;
  logic                out_conn;
  logic [COST_W-1:0]   out_cost;
  logic                out_err;

  // memories
  logic [EDGE_W-1:0] edge_mem [MAX_EDGES];
  logic [EDGE_W-1:0] edge_q;
  logic [VW-1:0]     parent_mem [MAX_VERTICES];
  logic [VW-1:0]     par_q;
  logic [VW-1:0]     par_raddr;

  // fields of the edge read back
  logic [VERTEX_W-1:0] q_a;
  logic [VERTEX_W-1:0] q_b;
  logic [WEIGHT_W-1:0] q_w;
  assign q_a = edge_q[EDGE_W-1 -: VERTEX_W];
  assign q_b = edge_q[WEIGHT_W +: VERTEX_W];
  assign q_w = edge_q[WEIGHT_W-1:0];

  // input transaction decode
  logic in_acc;
  logic in_ok;
  assign in_edge.ready = (state == S_LOAD);
  assign in_acc = in_edge.valid && in_edge.ready;
  assign in_ok  = (32'(in_edge.first_vertex) < 32'(n_act))
               && (32'(in_edge.second_vertex) < 32'(n_act))
               && (32'(edge_count) < MAX_EDGES);

  assign out_res.valid       = out_valid;
  assign out_res.connected   = out_conn;
  assign out_res.total_cost  = out_cost;
  assign out_res.input_error = out_err;

  assign par_raddr = (state == S_FA_RD) ? ra : rb;

  always_ff @(posedge clk) begin
    if (in_acc && in_edge.edge_present && in_ok) begin
      edge_mem[edge_count[AW-1:0]] <= {in_edge.first_vertex, in_edge.second_vertex,
                                       in_edge.edge_weight};
    end
    edge_q <= edge_mem[idx[AW-1:0]];
  end

  always_ff @(posedge clk) begin
    if (state == S_CLR) begin
      parent_mem[clr] <= clr;
    end else if (state == S_UNION && ra != rb) begin
      parent_mem[ra] <= rb;
    end
    par_q <= parent_mem[par_raddr];
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_LOAD;
      num_vertices <= NVERT_W'(1);
      edge_count   <= '0;
      error_flag   <= 1'b0;
      out_valid    <= 1'b0;
      idx          <= '0;
      clr          <= '0;
      have_prev    <= 1'b0;
      found        <= 1'b0;
      comp_count   <= '0;
      acc_count    <= '0;
      cost_sum     <= '0;
      n_run        <= NW'(1);
    end else begin
      if (cfg_we) begin
        num_vertices <= cfg_wdata;
      end
      if (out_valid && out_res.ready) begin
        out_valid <= 1'b0;
      end

      unique case (state)
        S_LOAD: begin
          if (in_acc) begin
            // a present edge that is dropped, the last one included, raises the flag
            if (in_edge.edge_present) begin
              if (in_ok) begin
                edge_count <= edge_count + EW'(1);
              end else begin
                error_flag <= 1'b1;
              end
            end
            if (in_edge.last_edge) begin
              n_run      <= n_act;
              comp_count <= n_act;
              acc_count  <= '0;
              cost_sum   <= '0;
              clr        <= '0;
              state      <= S_CLR;
            end
          end
        end

        // every parent back to itself
        S_CLR: begin
          clr <= clr + VW'(1);
          if (clr == VW'(MAX_VERTICES - 1)) begin
            have_prev <= 1'b0;
            found     <= 1'b0;
            idx       <= '0;
            state     <= S_MIN_RD;
          end
        end

        // search the smallest weight above the last one handled
        S_MIN_RD: begin
          if (idx == edge_count) begin
            if (!found) begin
              state <= S_DONE;
            end else begin
              cur_w <= min_w;
              idx   <= '0;
              state <= S_PR_RD;
            end
          end else begin
            state <= S_MIN_CHK;
          end
        end

        S_MIN_CHK: begin
          if ((!have_prev || q_w > prev_w) && (!found || q_w < min_w)) begin
            min_w <= q_w;
            found <= 1'b1;
          end
          idx   <= idx + EW'(1);
          state <= S_MIN_RD;
        end

        // handle every edge of the current weight, until the tree is complete
        S_PR_RD: begin
          if (idx == edge_count) begin
            prev_w    <= cur_w;
            have_prev <= 1'b1;
            found     <= 1'b0;
            idx       <= '0;
            state     <= S_MIN_RD;
          end else begin
            state <= S_PR_CHK;
          end
        end

        S_PR_CHK: begin
          if (q_w != cur_w) begin
            idx   <= idx + EW'(1);
            state <= S_PR_RD;
          end else if (32'(acc_count) + 32'd1 >= 32'(n_run)) begin
            // tree complete
            state <= S_DONE;
          end else if ((32'(q_a) >= 32'(n_run)) || (32'(q_b) >= 32'(n_run))) begin
            idx   <= idx + EW'(1);
            state <= S_PR_RD;
          end else begin
            ra    <= VW'(q_a);
            rb    <= VW'(q_b);
            state <= S_FA_RD;
          end
        end

        S_FA_RD: state <= S_FA_CHK;

        S_FA_CHK: begin
          if (par_q == ra) begin
            state <= S_FB_RD;
          end else begin
            ra    <= par_q;
            state <= S_FA_RD;
          end
        end

        S_FB_RD: state <= S_FB_CHK;

        S_FB_CHK: begin
          if (par_q == rb) begin
            state <= S_UNION;
          end else begin
            rb    <= par_q;
            state <= S_FB_RD;
          end
        end

        // join two components (parent write happens in the memory block)
        S_UNION: begin
          if (ra != rb) begin
            comp_count <= comp_count - NW'(1);
            acc_count  <= acc_count + NW'(1);
            cost_sum   <= cost_sum + COST_W'(cur_w);
          end
          idx   <= idx + EW'(1);
          state <= S_PR_RD;
        end

        // hand over once the result register is free
        S_DONE: begin
          if (!out_valid) begin
            out_valid  <= 1'b1;
            out_conn   <= (comp_count == NW'(1));
            out_cost   <= cost_sum;
            out_err    <= error_flag;
            edge_count <= '0;
            error_flag <= 1'b0;
            state      <= S_LOAD;
          end
        end

        default: state <= S_LOAD;
      endcase
    end
  end

endmodule

`default_nettype wire
